[rtl/core/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console writer: request and
// response payloads, the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // default screen geometry
   localparam int unsigned COLUMNS_DEFAULT = 80;
   localparam int unsigned ROWS_DEFAULT    = 25;

   // character and attribute constants
   localparam logic [7:0] RESET_ATTR   = 8'h07;
   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;

   // operation codes
   localparam logic [2:0] OP_PUT_CHAR  = 3'd0;
   localparam logic [2:0] OP_CLEAR     = 3'd1;
   localparam logic [2:0] OP_COLOR_CLR = 3'd2;
   localparam logic [2:0] OP_FIND_END  = 3'd3;
   localparam logic [2:0] OP_READ_CELL = 3'd4;

   // register map
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam logic        CSR_IDX_ATTR = 1'b0;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  char_code;
      logic [3:0]  background;
      logic [3:0]  foreground;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_cell;
      logic [15:0] cell_data;
   } rsp_type;

   // datapath commands
   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_PUT,
      DP_FILL_START,
      DP_FILL_STEP,
      DP_SCROLL_START,
      DP_SCROLL_STEP,
      DP_FIND_START,
      DP_FIND_STEP,
      DP_READ_ISSUE,
      DP_READ_TAKE
   } dp_op_type;

   // source of the attribute for a fill sweep
   typedef enum logic [1:0] {
      FILL_RESET,
      FILL_TEXT,
      FILL_COLOR
   } fill_sel_type;

   typedef struct packed {
      dp_op_type    dp_op;
      fill_sel_type fill_sel;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] operation;
      logic       at_end;
      logic       sweep_last;
      logic       find_hit;
      logic       scan_first;
   } dp_status_type;

   function automatic logic [15:0] blank_word(input logic [7:0] attr);
      return {attr, BLANK_CHAR};
   endfunction

endpackage

[rtl/core/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen store, cursor, sweep counter and result registers. Executes one
// command from the controller each cycle and reports status back.
// ----------------------------------------------------------------------------
module tcw_datapath #(
   parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tcw_pkg::ctl_cmd_type  cmd,
   input  tcw_pkg::req_type      req_payload,
   input  logic [7:0]            text_attr,
   output tcw_pkg::dp_status_type status,
   output tcw_pkg::rsp_type      rsp_payload
);

   localparam int unsigned CELLS = COLUMNS * ROWS;
   localparam int unsigned CW    = $clog2(CELLS + 1);
   localparam int unsigned AW    = $clog2(CELLS);
   localparam int unsigned COLW  = $clog2(COLUMNS);

   localparam logic [CW-1:0]   CELLS_C   = CW'(CELLS);
   localparam logic [CW-1:0]   COLS_C    = CW'(COLUMNS);
   localparam logic [AW-1:0]   LAST_ADDR = AW'(CELLS - 1);
   localparam logic [AW-1:0]   COPY_END  = AW'(CELLS - COLUMNS);
   localparam logic [AW-1:0]   COLS_ADDR = AW'(COLUMNS);
   localparam logic [COLW-1:0] LAST_COL  = COLW'(COLUMNS - 1);

   // screen store
   logic [15:0] mem [CELLS];

   tcw_pkg::req_type req_ff, req_in;
   logic [CW-1:0]   cursor_ff, cursor_in;
   logic [COLW-1:0] col_ff, col_in;
   logic [AW-1:0]   sweep_ff, sweep_in;
   logic [COLW-1:0] scan_col_ff, scan_col_in;
   logic [15:0]     fill_word_ff, fill_word_in;
   logic [15:0]     rd_data_ff;
   logic [15:0]     cell_data_ff, cell_data_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [15:0]     wr_data;
   logic [AW-1:0]   rd_addr;

   logic [CW-1:0]   cur_dec;
   logic [CW-1:0]   row_base;
   logic [COLW-1:0] col_inc;
   logic [COLW-1:0] col_dec;
   logic [COLW-1:0] scan_col_inc;
   logic [COLW-1:0] scan_col_dec;
   logic [CW:0]     copy_src;
   logic [CW+10:0]  idx_wide;
   logic [CW+10:0]  cur_wide;
   logic            idx_ok;
   logic            find_hit;

   // helper arithmetic
   assign cur_dec      = cursor_ff - CW'(1);
   assign row_base     = cursor_ff - CW'(col_ff);
   assign col_inc      = (col_ff == LAST_COL) ? '0 : col_ff + COLW'(1);
   assign col_dec      = (col_ff == '0) ? LAST_COL : col_ff - COLW'(1);
   assign scan_col_inc = (scan_col_ff == LAST_COL) ? '0 : scan_col_ff + COLW'(1);
   assign scan_col_dec = (scan_col_ff == '0) ? LAST_COL : scan_col_ff - COLW'(1);
   assign copy_src     = (CW+1)'(sweep_ff) + (CW+1)'(COLUMNS + 1);
   assign idx_wide     = (CW+11)'(req_ff.cell_index);
   assign idx_ok       = idx_wide < (CW+11)'(CELLS);
   assign find_hit     = (rd_data_ff[7:0] != 8'h00) && (rd_data_ff[7:0] != tcw_pkg::BLANK_CHAR);

   // command execution
   always_comb begin
      req_in       = req_ff;
      cursor_in    = cursor_ff;
      col_in       = col_ff;
      sweep_in     = sweep_ff;
      scan_col_in  = scan_col_ff;
      fill_word_in = fill_word_ff;
      cell_data_in = cell_data_ff;
      wr_en        = 1'b0;
      wr_addr      = cursor_ff[AW-1:0];
      wr_data      = {text_attr, req_ff.char_code};
      rd_addr      = '0;

      case (cmd.dp_op)
         tcw_pkg::DP_LOAD: begin
            req_in       = req_payload;
            cell_data_in = '0;
         end
         tcw_pkg::DP_PUT: begin
            case (req_ff.char_code)
               tcw_pkg::CH_NEWLINE: begin
                  cursor_in = row_base + COLS_C;
                  col_in    = '0;
               end
               tcw_pkg::CH_RETURN: begin
                  cursor_in = row_base;
                  col_in    = '0;
               end
               tcw_pkg::CH_BACKSPACE: begin
                  if (cursor_ff != '0) begin
                     cursor_in = cur_dec;
                     col_in    = col_dec;
                     wr_en     = 1'b1;
                     wr_addr   = cur_dec[AW-1:0];
                     wr_data   = tcw_pkg::blank_word(text_attr);
                  end
               end
               default: begin
                  wr_en     = 1'b1;
                  cursor_in = cursor_ff + CW'(1);
                  col_in    = col_inc;
               end
            endcase
         end
         tcw_pkg::DP_FILL_START: begin
            sweep_in  = '0;
            cursor_in = '0;
            col_in    = '0;
            case (cmd.fill_sel)
               tcw_pkg::FILL_TEXT:  fill_word_in = tcw_pkg::blank_word(text_attr);
               tcw_pkg::FILL_COLOR: fill_word_in =
                  tcw_pkg::blank_word({req_ff.background, req_ff.foreground});
               default:             fill_word_in = tcw_pkg::blank_word(tcw_pkg::RESET_ATTR);
            endcase
         end
         tcw_pkg::DP_FILL_STEP: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = fill_word_ff;
            sweep_in = sweep_ff + AW'(1);
         end
         tcw_pkg::DP_SCROLL_START: begin
            sweep_in  = '0;
            rd_addr   = COLS_ADDR;
            cursor_in = cursor_ff - COLS_C;
         end
         tcw_pkg::DP_SCROLL_STEP: begin
            // copy the row below, blank the bottom row
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = (sweep_ff < COPY_END) ? rd_data_ff : tcw_pkg::blank_word(text_attr);
            sweep_in = sweep_ff + AW'(1);
            rd_addr  = (copy_src < (CW+1)'(CELLS)) ? copy_src[AW-1:0] : '0;
         end
         tcw_pkg::DP_FIND_START: begin
            sweep_in    = LAST_ADDR;
            scan_col_in = LAST_COL;
            rd_addr     = LAST_ADDR;
         end
         tcw_pkg::DP_FIND_STEP: begin
            // rd_data_ff holds the cell at sweep_ff
            if (find_hit) begin
               cursor_in = CW'(sweep_ff) + CW'(1);
               col_in    = scan_col_inc;
            end else if (sweep_ff == '0) begin
               cursor_in = '0;
               col_in    = '0;
            end else begin
               sweep_in    = sweep_ff - AW'(1);
               scan_col_in = scan_col_dec;
               rd_addr     = sweep_ff - AW'(1);
            end
         end
         tcw_pkg::DP_READ_ISSUE: begin
            rd_addr = idx_ok ? idx_wide[AW-1:0] : '0;
         end
         tcw_pkg::DP_READ_TAKE: begin
            cell_data_in = idx_ok ? rd_data_ff : '0;
         end
         default: begin
         end
      endcase
   end

   // screen store ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // cursor
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         col_ff    <= '0;
      end else begin
         cursor_ff <= cursor_in;
         col_ff    <= col_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      sweep_ff     <= sweep_in;
      scan_col_ff  <= scan_col_in;
      fill_word_ff <= fill_word_in;
      cell_data_ff <= cell_data_in;
   end

   // status and result
   assign cur_wide = (CW+11)'(cursor_ff);

   always_comb begin
      status.operation  = req_ff.operation;
      status.at_end     = (cursor_ff == CELLS_C);
      status.sweep_last = (sweep_ff == LAST_ADDR);
      status.find_hit   = find_hit;
      status.scan_first = (sweep_ff == '0);
      rsp_payload.cursor_cell = cur_wide[10:0];
      rsp_payload.cell_data   = cell_data_ff;
   end

endmodule

[rtl/core/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller state machine: runs the clearing pass after reset, takes one
// transaction at a time and sequences the datapath through each operation.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  tcw_pkg::dp_status_type status,
   output tcw_pkg::ctl_cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_INIT_FILL,
      ST_IDLE,
      ST_DECODE,
      ST_POST,
      ST_SCROLL,
      ST_FILL,
      ST_FIND,
      ST_READ,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;

   // next state and datapath command
   always_comb begin
      state_in     = state_ff;
      cmd.dp_op    = tcw_pkg::DP_NONE;
      cmd.fill_sel = tcw_pkg::FILL_TEXT;

      case (state_ff)
         ST_INIT: begin
            cmd.dp_op    = tcw_pkg::DP_FILL_START;
            cmd.fill_sel = tcw_pkg::FILL_RESET;
            state_in     = ST_INIT_FILL;
         end
         ST_INIT_FILL: begin
            cmd.dp_op = tcw_pkg::DP_FILL_STEP;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.dp_op = tcw_pkg::DP_LOAD;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.operation)
               tcw_pkg::OP_PUT_CHAR: begin
                  cmd.dp_op = tcw_pkg::DP_PUT;
                  state_in  = ST_POST;
               end
               tcw_pkg::OP_CLEAR: begin
                  cmd.dp_op = tcw_pkg::DP_FILL_START;
                  state_in  = ST_FILL;
               end
               tcw_pkg::OP_COLOR_CLR: begin
                  cmd.dp_op    = tcw_pkg::DP_FILL_START;
                  cmd.fill_sel = tcw_pkg::FILL_COLOR;
                  state_in     = ST_FILL;
               end
               tcw_pkg::OP_FIND_END: begin
                  cmd.dp_op = tcw_pkg::DP_FIND_START;
                  state_in  = ST_FIND;
               end
               tcw_pkg::OP_READ_CELL: begin
                  cmd.dp_op = tcw_pkg::DP_READ_ISSUE;
                  state_in  = ST_READ;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_POST: begin
            // cursor ran past the last cell: scroll one row
            if (status.at_end) begin
               cmd.dp_op = tcw_pkg::DP_SCROLL_START;
               state_in  = ST_SCROLL;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SCROLL: begin
            cmd.dp_op = tcw_pkg::DP_SCROLL_STEP;
            if (status.sweep_last) begin
               state_in = ST_RESP;
            end
         end
         ST_FILL: begin
            cmd.dp_op = tcw_pkg::DP_FILL_STEP;
            if (status.sweep_last) begin
               state_in = ST_RESP;
            end
         end
         ST_FIND: begin
            cmd.dp_op = tcw_pkg::DP_FIND_STEP;
            if (status.find_hit) begin
               state_in = ST_POST;
            end else if (status.scan_first) begin
               state_in = ST_RESP;
            end
         end
         ST_READ: begin
            cmd.dp_op = tcw_pkg::DP_READ_TAKE;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

[rtl/core/text_console_writer_core.sv]
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell text console: put character, clear, colored clear, find end
// and read cell over a COLUMNS x ROWS screen store, with an APB attribute reg.
// ----------------------------------------------------------------------------
// Clear sweeps every cell; a put or find end that leaves the cursor past the last
//   cell adds a scroll; find end scans one cell a cycle from the last cell down.
// One transaction at a time, the next taken the cycle after the result is accepted.
// After reset the store is filled with blanks (attribute 7) with req_ready low;
//   register writes are taken during that pass.
module text_console_writer_core #(
   parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tcw_pkg::req_type              req_payload,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tcw_pkg::rsp_type              rsp_payload,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic [7:0]              attr_ff;
   logic                    csr_write;
   logic                    csr_hit;
   tcw_pkg::ctl_cmd_type    cmd;
   tcw_pkg::dp_status_type  status;

   // attribute register
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == tcw_pkg::CSR_IDX_ATTR);
   assign csr_write = psel & penable & pwrite & pready & csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcw_pkg::RESET_ATTR;
      end else if (csr_write) begin
         attr_ff <= pwdata[7:0];
      end
   end

   assign prdata = csr_hit ? {24'h000000, attr_ff} : 32'h00000000;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .text_attr   (attr_ff),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

[dv/text_console_writer_core_tb.sv]
// ----------------------------------------------------------------------------
// text_console_writer_core_tb
// Self-checking bench for the text console writer. A queue of requests feeds
// a clocked driver; a clocked monitor predicts each accepted transaction with
// a local screen and cursor copy and checks every response in order. Phases
// vary the text attribute and the idle/stall pressure on both channels.
// ----------------------------------------------------------------------------
module text_console_writer_core_tb;
   import tcw_pkg::*;

   localparam int unsigned COLS  = COLUMNS_DEFAULT;
   localparam int unsigned CELLS = COLUMNS_DEFAULT * ROWS_DEFAULT;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // stimulus and scoreboard state
   req_type     pending_q[$];
   rsp_type     expected_q[$];
   bit          req_taken = 1'b0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned mismatch_count = 0;

   // local copy of the console
   logic [15:0] screen_model [0:CELLS-1];
   int unsigned cursor_model;
   logic [7:0]  attr_model;

   text_console_writer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // run limit: far above the slowest legal run
   initial begin
      #(64'd40_000_000);
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // console predictor
   // ------------------------------------------------------------------------
   function automatic void blank_screen(input logic [7:0] attr);
      for (int i = 0; i < CELLS; i++) screen_model[i] = {attr, BLANK_CHAR};
      cursor_model = 0;
   endfunction

   // shift rows up once the cursor has run off the last cell
   function automatic void scroll_past_end();
      if (cursor_model >= CELLS) begin
         for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
         for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = {attr_model, BLANK_CHAR};
         cursor_model = cursor_model - COLS;
      end
   endfunction

   function automatic void print_char(input logic [7:0] code);
      if (code == CH_NEWLINE) begin
         cursor_model = cursor_model + COLS - (cursor_model % COLS);
      end else if (code == CH_RETURN) begin
         cursor_model = cursor_model - (cursor_model % COLS);
      end else if (code == CH_BACKSPACE) begin
         if (cursor_model > 0) begin
            cursor_model = cursor_model - 1;
            screen_model[cursor_model] = {attr_model, BLANK_CHAR};
         end
      end else begin
         screen_model[cursor_model] = {attr_model, code};
         cursor_model = cursor_model + 1;
      end
      scroll_past_end();
   endfunction

   // cursor lands just after the last cell holding text
   function automatic void seek_text_end();
      int unsigned pos;
      bit          hit;
      pos = CELLS;
      hit = 1'b0;
      while (pos > 0 && !hit) begin
         if (screen_model[pos-1][7:0] != 8'h00 && screen_model[pos-1][7:0] != BLANK_CHAR)
            hit = 1'b1;
         else
            pos = pos - 1;
      end
      cursor_model = pos;
      scroll_past_end();
   endfunction

   function automatic rsp_type console_predict(input req_type item);
      rsp_type result;
      result = '0;
      case (item.operation)
         OP_PUT_CHAR:  print_char(item.char_code);
         OP_CLEAR:     blank_screen(attr_model);
         OP_COLOR_CLR: blank_screen({item.background, item.foreground});
         OP_FIND_END:  seek_text_end();
         OP_READ_CELL: begin
            if (item.cell_index < CELLS) result.cell_data = screen_model[item.cell_index];
         end
         default: ;
      endcase
      result.cursor_cell = 11'(cursor_model);
      return result;
   endfunction

   // ------------------------------------------------------------------------
   // request driver: holds valid and payload until the transaction is taken
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_payload <= pending_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------------
   // monitor: predict on request accept, check on response accept
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_q.push_back(console_predict(req_payload));
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response with nothing outstanding: cursor %0d data %04h",
                      rsp_payload.cursor_cell, rsp_payload.cell_data);
               mismatch_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_payload.cursor_cell !== want.cursor_cell) begin
                  $error("cursor_cell expected %0d got %0d",
                         want.cursor_cell, rsp_payload.cursor_cell);
                  mismatch_count++;
               end
               if (rsp_payload.cell_data !== want.cell_data) begin
                  $error("cell_data expected %04h got %04h",
                         want.cell_data, rsp_payload.cell_data);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic req_type make_req(input logic [2:0] op, input logic [7:0] code,
                                        input logic [3:0] bg, input logic [3:0] fg,
                                        input logic [10:0] idx);
      req_type item;
      item.operation  = op;
      item.char_code  = code;
      item.background = bg;
      item.foreground = fg;
      item.cell_index = idx;
      return item;
   endfunction

   // general traffic, mostly characters with all control codes mixed in
   function automatic req_type random_req();
      req_type     item;
      int unsigned pick;
      item = make_req(OP_PUT_CHAR, 8'($urandom), 4'($urandom), 4'($urandom),
                      11'($urandom_range(CELLS - 1)));
      pick = $urandom_range(999);
      if (pick < 860) begin
         pick = $urandom_range(99);
         if (pick < 12)      item.char_code = CH_NEWLINE;
         else if (pick < 16) item.char_code = CH_RETURN;
         else if (pick < 24) item.char_code = CH_BACKSPACE;
         else if (pick < 27) item.char_code = 8'h00;
         else if (pick < 31) item.char_code = BLANK_CHAR;
      end else if (pick < 930) begin
         item.operation = OP_READ_CELL;
         if ($urandom_range(9) == 0) item.cell_index = 11'($urandom_range(2047, CELLS));
      end else if (pick < 936) begin
         item.operation = OP_CLEAR;
      end else if (pick < 942) begin
         item.operation = OP_COLOR_CLR;
      end else if (pick < 975) begin
         item.operation = OP_FIND_END;
      end else begin
         item.operation = 3'($urandom_range(7, 5));
      end
      return item;
   endfunction

   // line-heavy text that walks the cursor down the screen and forces scrolls
   function automatic req_type line_req();
      req_type item;
      item = random_req();
      item.operation = OP_PUT_CHAR;
      item.char_code = ($urandom_range(99) < 55) ? CH_NEWLINE : 8'($urandom_range(8'h7E, 8'h21));
      return item;
   endfunction

   // checked at the rising edge, where valid is settled, then back to a falling edge
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0);
      @(negedge clock);
   endtask

   // attribute write followed by a read-back
   task automatic write_attr(input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * CSR_IDX_ATTR);
      pwdata  <= {24'h0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      attr_model = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      if (prdata[7:0] !== value) begin
         $error("text_attribute expected %02h got %02h", value, prdata[7:0]);
         mismatch_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic fill_random(input int unsigned count);
      int unsigned made;
      int unsigned burst;
      made = 0;
      while (made < count) begin
         if ($urandom_range(99) < 4) begin
            burst = $urandom_range(30, 12);
            repeat (burst) pending_q.push_back(line_req());
            made += burst;
         end else begin
            pending_q.push_back(random_req());
            made++;
         end
      end
   endtask

   // one phase: idle block, new attribute, new pressure, random traffic
   task automatic run_phase(input int unsigned count, input int unsigned send_pct,
                            input int unsigned recv_pct, input logic [7:0] attr,
                            input bit pause_midway);
      wait_drained();
      write_attr(attr);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (pause_midway) begin
         fill_random(count / 2);
         wait_drained();
         fill_random(count - count / 2);
      end else begin
         fill_random(count);
      end
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      attr_model = RESET_ATTR;
      blank_screen(RESET_ATTR);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: edge cases at the reset attribute
      pending_q.push_back(make_req(OP_PUT_CHAR, CH_BACKSPACE, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(OP_READ_CELL, 8'hFF, 4'hF, 4'hF, 11'd0));
      pending_q.push_back(make_req(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 11'(CELLS - 1)));
      pending_q.push_back(make_req(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 11'(CELLS)));
      pending_q.push_back(make_req(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 11'h7FF));
      pending_q.push_back(make_req(OP_FIND_END, 8'h00, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(OP_PUT_CHAR, 8'h41, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(OP_PUT_CHAR, 8'h00, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(OP_PUT_CHAR, 8'hFF, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(OP_PUT_CHAR, BLANK_CHAR, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(OP_PUT_CHAR, CH_RETURN, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(OP_PUT_CHAR, 8'h42, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(OP_PUT_CHAR, CH_NEWLINE, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(OP_PUT_CHAR, CH_BACKSPACE, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(OP_FIND_END, 8'h00, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(3'd5, 8'hFF, 4'hF, 4'hF, 11'h7FF));
      pending_q.push_back(make_req(3'd6, 8'h00, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(3'd7, 8'hFF, 4'hF, 4'hF, 11'h7FF));
      pending_q.push_back(make_req(OP_COLOR_CLR, 8'h00, 4'hF, 4'h0, 11'd0));
      pending_q.push_back(make_req(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 11'd5));
      pending_q.push_back(make_req(OP_COLOR_CLR, 8'hFF, 4'h0, 4'hF, 11'd0));
      pending_q.push_back(make_req(OP_FIND_END, 8'h00, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(OP_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0));
      pending_q.push_back(make_req(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 11'(CELLS - 1)));

      // random phases across attribute extremes and channel pressure
      run_phase(330, 0, 0, 8'h00, 1'b0);
      run_phase(330, 84, 0, 8'hFF, 1'b0);
      run_phase(330, 0, 84, 8'($urandom), 1'b0);
      run_phase(330, 35, 35, 8'($urandom), 1'b1);
      run_phase(330, 0, 0, 8'($urandom), 1'b0);

      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
